// ===== rtl/lmdd_pkg.sv =====
// Package for the lock manager deadlock detector: item structs, command codes,
// result codes and the command/status structs between controller and datapath.
// No dependencies.
package lmdd_pkg;

  localparam int NUM_PROC  = 16;
  localparam int NUM_RES   = 16;
  localparam int ID_W      = 4;
  localparam int NODES     = NUM_PROC + NUM_RES;
  localparam int NODE_W    = 5;
  localparam int LEN_W     = 9;   // holds a length up to 511
  localparam int IDX_W     = 8;   // index below 256
  localparam int CNT_W     = 6;

  typedef enum logic [1:0] {
    MODE_REQUEST = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_CHECK   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_AVAIL = 3'd0,
    ST_WAIT  = 3'd1,
    ST_TERM  = 3'd2,
    ST_KILL  = 3'd3,
    ST_NONE  = 3'd4,
    ST_FULL  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    TBL_RQ   = 2'd0,
    TBL_HELD = 2'd1,
    TBL_WANT = 2'd2
  } tbl_e;

  typedef enum logic [1:0] {
    LOP_NONE = 2'd0,
    LOP_INC  = 2'd1,
    LOP_DEC  = 2'd2
  } lop_e;

  localparam logic [1:0] COL_WHITE = 2'd0;
  localparam logic [1:0] COL_GREY  = 2'd1;
  localparam logic [1:0] COL_BLACK = 2'd2;

  typedef struct packed {
    logic [1:0]      mode;
    logic [ID_W-1:0] process_id;
    logic [ID_W-1:0] resource_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] first_count;
    logic [4:0] second_count;
  } out_item_t;

  typedef struct packed {
    tbl_e              a_sel;
    logic [ID_W-1:0]   a_row;
    lop_e              len_op;
    tbl_e              b_sel;
    logic [ID_W-1:0]   b_row;
    logic              rd_en;
    tbl_e              rd_sel;
    logic [ID_W-1:0]   rd_row;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    tbl_e              wr_sel;
    logic [ID_W-1:0]   wr_row;
    logic [IDX_W-1:0]  wr_idx;
    logic [ID_W-1:0]   wr_data;
    logic              known_set;
    logic [ID_W-1:0]   known_row;
    logic              dfs_init;
    logic [ID_W-1:0]   dfs_root;
    logic              dfs_pop;
    logic              dfs_edge_inc;
    logic              dfs_push;
    logic [NODE_W-1:0] t_node;
  } dp_cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0]    a_len;
    logic [LEN_W-1:0]    b_len;
    logic [ID_W-1:0]     rdata;
    logic [NUM_PROC-1:0] known;
    logic                sp_zero;
    logic                sp_full;
    logic [NODE_W-1:0]   top_node;
    logic [LEN_W-1:0]    top_edge;
    logic [1:0]          t_color;
  } dp_stat_t;

endpackage

// ===== rtl/lock_manager_deadlock_detect_core.sv =====
// Lock manager with deadlock detection over a resource allocation graph.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one command per
// transfer: request, free process or deadlock check. The core takes one
// command at a time; in_stall_o is high while a command is in progress.
// Output channel (out_valid_o / out_stall_i / out_data_o): at most one result
// per command, held in an output register, so the next command is taken while
// a result still waits for the receiver. A stalled result holds its value.
// A request checks the process lists, then the resource queue, then writes
// the held or wanted list; it ends early when the lists or the queue are full.
// Free and kill walk the held and wanted lists and the resource queues entry
// by entry through one memory port; a check follows the graph edges one at a
// time. The run time of free and kill is set by the list sweeps.
// Free of an unknown process and the unused mode give no result.
// Reset clears all lengths, process flags and the controller; list contents
// need no clearing since they are read only below their lengths.
// Depends on lmdd_pkg, lmdd_ctrl and lmdd_dpath.
module lock_manager_deadlock_detect_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int LIST_DEPTH  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lmdd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lmdd_pkg::out_item_t out_data_o
);
  import lmdd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lmdd_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  lmdd_dpath #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .stat_o(stat)
  );

endmodule

// ===== rtl/lmdd_dpath.sv =====
// Datapath: resource queues, held and wanted lists (memories), their lengths,
// the known-process flags and the search colors and stack.
// Depends on lmdd_pkg.
module lmdd_dpath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int LIST_DEPTH  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lmdd_pkg::dp_cmd_t cmd_i,
  output lmdd_pkg::dp_stat_t stat_o
);
  import lmdd_pkg::*;

  localparam int QAW = $clog2(NUM_RES * QUEUE_DEPTH);
  localparam int LAW = $clog2(NUM_PROC * LIST_DEPTH);
  localparam int QLW = $clog2(QUEUE_DEPTH + 1);
  localparam int LLW = $clog2(LIST_DEPTH + 1);

  logic [ID_W-1:0] rq_mem   [NUM_RES*QUEUE_DEPTH];
  logic [ID_W-1:0] held_mem [NUM_PROC*LIST_DEPTH];
  logic [ID_W-1:0] want_mem [NUM_PROC*LIST_DEPTH];

  logic [QLW-1:0] rq_len_q   [NUM_RES];
  logic [LLW-1:0] held_len_q [NUM_PROC];
  logic [LLW-1:0] want_len_q [NUM_PROC];
  logic [NUM_PROC-1:0] known_q;

  logic [1:0]        color_q    [NODES];
  logic [NODE_W-1:0] stk_node_q [NODES];
  logic [LEN_W-1:0]  stk_edge_q [NODES];
  logic [NODE_W:0]   sp_q;
  logic [NODE_W-1:0] top_idx;

  logic [ID_W-1:0] rq_rd_q, held_rd_q, want_rd_q;
  tbl_e            rd_sel_q;

  logic [ID_W-1:0]  rdata;
  logic [LEN_W-1:0] a_len, b_len;

  logic [QAW-1:0] q_wa, q_ra;
  logic [LAW-1:0] l_wa, l_ra;

  assign q_wa = QAW'(cmd_i.wr_row) * QAW'(QUEUE_DEPTH) + QAW'(cmd_i.wr_idx);
  assign q_ra = QAW'(cmd_i.rd_row) * QAW'(QUEUE_DEPTH) + QAW'(cmd_i.rd_idx);
  assign l_wa = LAW'(cmd_i.wr_row) * LAW'(LIST_DEPTH) + LAW'(cmd_i.wr_idx);
  assign l_ra = LAW'(cmd_i.rd_row) * LAW'(LIST_DEPTH) + LAW'(cmd_i.rd_idx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_i.wr_sel == TBL_RQ) rq_mem[q_wa] <= cmd_i.wr_data;
    if (cmd_i.rd_en && cmd_i.rd_sel == TBL_RQ) rq_rd_q <= rq_mem[q_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_i.wr_sel == TBL_HELD) held_mem[l_wa] <= cmd_i.wr_data;
    if (cmd_i.rd_en && cmd_i.rd_sel == TBL_HELD) held_rd_q <= held_mem[l_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_i.wr_sel == TBL_WANT) want_mem[l_wa] <= cmd_i.wr_data;
    if (cmd_i.rd_en && cmd_i.rd_sel == TBL_WANT) want_rd_q <= want_mem[l_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_sel_q <= TBL_RQ;
    end else if (cmd_i.rd_en) begin
      rd_sel_q <= cmd_i.rd_sel;
    end
  end

  always_comb begin
    case (rd_sel_q)
      TBL_RQ:   rdata = rq_rd_q;
      TBL_HELD: rdata = held_rd_q;
      TBL_WANT: rdata = want_rd_q;
      default:  rdata = '0;
    endcase
  end

  // Length lookups
  always_comb begin
    case (cmd_i.a_sel)
      TBL_RQ:   a_len = LEN_W'(rq_len_q[cmd_i.a_row]);
      TBL_HELD: a_len = LEN_W'(held_len_q[cmd_i.a_row]);
      TBL_WANT: a_len = LEN_W'(want_len_q[cmd_i.a_row]);
      default:  a_len = '0;
    endcase
    case (cmd_i.b_sel)
      TBL_RQ:   b_len = LEN_W'(rq_len_q[cmd_i.b_row]);
      TBL_HELD: b_len = LEN_W'(held_len_q[cmd_i.b_row]);
      TBL_WANT: b_len = LEN_W'(want_len_q[cmd_i.b_row]);
      default:  b_len = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_RES; i++) rq_len_q[i] <= '0;
      for (int i = 0; i < NUM_PROC; i++) begin
        held_len_q[i] <= '0;
        want_len_q[i] <= '0;
      end
      known_q <= '0;
    end else begin
      if (cmd_i.known_set) known_q[cmd_i.known_row] <= 1'b1;
      case (cmd_i.len_op)
        LOP_INC: begin
          case (cmd_i.a_sel)
            TBL_RQ:   rq_len_q[cmd_i.a_row] <= rq_len_q[cmd_i.a_row] + QLW'(1);
            TBL_HELD: held_len_q[cmd_i.a_row] <= held_len_q[cmd_i.a_row] + LLW'(1);
            TBL_WANT: want_len_q[cmd_i.a_row] <= want_len_q[cmd_i.a_row] + LLW'(1);
            default: ;
          endcase
        end
        LOP_DEC: begin
          case (cmd_i.a_sel)
            TBL_RQ:   rq_len_q[cmd_i.a_row] <= rq_len_q[cmd_i.a_row] - QLW'(1);
            TBL_HELD: held_len_q[cmd_i.a_row] <= held_len_q[cmd_i.a_row] - LLW'(1);
            TBL_WANT: want_len_q[cmd_i.a_row] <= want_len_q[cmd_i.a_row] - LLW'(1);
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Cycle search: colors and explicit stack
  assign top_idx = NODE_W'(sp_q - (NODE_W+1)'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      for (int i = 0; i < NODES; i++) color_q[i] <= COL_WHITE;
    end else if (cmd_i.dfs_init) begin
      for (int i = 0; i < NODES; i++) color_q[i] <= COL_WHITE;
      color_q[{1'b0, cmd_i.dfs_root}] <= COL_GREY;
      sp_q <= (NODE_W+1)'(1);
    end else if (cmd_i.dfs_pop) begin
      color_q[stk_node_q[top_idx]] <= COL_BLACK;
      sp_q <= sp_q - (NODE_W+1)'(1);
    end else if (cmd_i.dfs_push) begin
      color_q[cmd_i.t_node] <= COL_GREY;
      sp_q <= sp_q + (NODE_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dfs_init) begin
      stk_node_q[0] <= {1'b0, cmd_i.dfs_root};
      stk_edge_q[0] <= '0;
    end else if (cmd_i.dfs_push) begin
      stk_node_q[sp_q[NODE_W-1:0]] <= cmd_i.t_node;
      stk_edge_q[sp_q[NODE_W-1:0]] <= '0;
    end else if (cmd_i.dfs_edge_inc) begin
      stk_edge_q[top_idx] <= stk_edge_q[top_idx] + LEN_W'(1);
    end
  end

  assign stat_o = '{
    a_len:    a_len,
    b_len:    b_len,
    rdata:    rdata,
    known:    known_q,
    sp_zero:  (sp_q == '0),
    sp_full:  (sp_q == (NODE_W+1)'(NODES)),
    top_node: stk_node_q[top_idx],
    top_edge: stk_edge_q[top_idx],
    t_color:  color_q[cmd_i.t_node]
  };

endmodule

// ===== rtl/lmdd_ctrl.sv =====
// Controller: command sequencer for request, release and cycle search,
// plus the input handshake and the output register.
// Depends on lmdd_pkg.
module lmdd_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int LIST_DEPTH  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lmdd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lmdd_pkg::out_item_t out_data_o,
  output lmdd_pkg::dp_cmd_t   cmd_o,
  input  lmdd_pkg::dp_stat_t  stat_i
);
  import lmdd_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE = 21'h000001,
    S_RQ0  = 21'h000002,
    S_RQ1  = 21'h000004,
    S_RQ2  = 21'h000008,
    S_RQ3  = 21'h000010,
    S_CK0  = 21'h000020,
    S_D1   = 21'h000040,
    S_D2   = 21'h000080,
    S_H0   = 21'h000100,
    S_H1   = 21'h000200,
    S_H2   = 21'h000400,
    S_H3   = 21'h000800,
    S_H5   = 21'h001000,
    S_W0   = 21'h002000,
    S_W1   = 21'h004000,
    S_W2   = 21'h008000,
    S_SH   = 21'h010000,
    S_SHW  = 21'h020000,
    S_FD   = 21'h040000,
    S_FDC  = 21'h080000,
    S_OUT  = 21'h100000
  } state_e;

  state_e st_q, st_d, ret_q, ret_d;
  logic [ID_W-1:0]  pid_q, pid_d, rid_q, rid_d, r_q, r_d, fv_q, fv_d;
  logic [ID_W-1:0]  sub_row_q, sub_row_d;
  tbl_e             sub_sel_q, sub_sel_d;
  logic [LEN_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] h_q, h_d, w_q, w_d;
  logic             kill_q, kill_d, tproc_q, tproc_d;
  out_item_t        res_q, res_d, out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic [LEN_W:0]   list_sum;
  logic [NODE_W-1:0] t_node;

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign list_sum    = {1'b0, stat_i.a_len} + {1'b0, stat_i.b_len};
  assign t_node      = tproc_q ? {1'b0, stat_i.rdata} : {1'b1, stat_i.rdata};

  always_comb begin
    st_d        = st_q;
    ret_d       = ret_q;
    pid_d       = pid_q;
    rid_d       = rid_q;
    r_d         = r_q;
    fv_d        = fv_q;
    sub_row_d   = sub_row_q;
    sub_sel_d   = sub_sel_q;
    pos_d       = pos_q;
    h_d         = h_q;
    w_d         = w_q;
    kill_d      = kill_q;
    tproc_d     = tproc_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.t_node = t_node;

    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pid_d = in_data_i.process_id;
          rid_d = in_data_i.resource_id;
          h_d   = '0;
          w_d   = '0;
          case (in_data_i.mode)
            MODE_REQUEST: st_d = S_RQ0;
            MODE_FREE: begin
              kill_d = 1'b0;
              if (stat_i.known[in_data_i.process_id]) st_d = S_H0;
            end
            MODE_CHECK: begin
              kill_d = 1'b1;
              if (stat_i.known[in_data_i.process_id]) begin
                st_d = S_CK0;
              end else begin
                res_d = '{status: ST_NONE, first_count: '0, second_count: '0};
                st_d  = S_OUT;
              end
            end
            default: ;
          endcase
        end
      end

      S_RQ0: begin
        cmd_o.a_sel = TBL_HELD;
        cmd_o.a_row = pid_q;
        cmd_o.b_sel = TBL_WANT;
        cmd_o.b_row = pid_q;
        if (list_sum >= (LEN_W+1)'(LIST_DEPTH)) begin
          res_d = '{status: ST_FULL, first_count: '0, second_count: '0};
          st_d  = S_OUT;
        end else begin
          st_d = S_RQ1;
        end
      end

      S_RQ1: begin
        cmd_o.a_sel   = TBL_RQ;
        cmd_o.a_row   = rid_q;
        cmd_o.wr_sel  = TBL_RQ;
        cmd_o.wr_row  = rid_q;
        cmd_o.wr_idx  = stat_i.a_len[IDX_W-1:0];
        cmd_o.wr_data = pid_q;
        cmd_o.known_row = pid_q;
        if (stat_i.a_len == '0) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.len_op    = LOP_INC;
          cmd_o.known_set = 1'b1;
          res_d = '{status: ST_AVAIL, first_count: '0, second_count: '0};
          st_d  = S_RQ2;
        end else if (stat_i.a_len >= LEN_W'(QUEUE_DEPTH)) begin
          res_d = '{status: ST_FULL, first_count: '0, second_count: '0};
          st_d  = S_OUT;
        end else begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.len_op    = LOP_INC;
          cmd_o.known_set = 1'b1;
          res_d = '{status: ST_WAIT, first_count: stat_i.a_len[5:0], second_count: '0};
          st_d  = S_RQ3;
        end
      end

      S_RQ2, S_RQ3: begin
        cmd_o.a_sel   = (st_q == S_RQ2) ? TBL_HELD : TBL_WANT;
        cmd_o.a_row   = pid_q;
        cmd_o.len_op  = LOP_INC;
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = cmd_o.a_sel;
        cmd_o.wr_row  = pid_q;
        cmd_o.wr_idx  = stat_i.a_len[IDX_W-1:0];
        cmd_o.wr_data = rid_q;
        st_d = S_OUT;
      end

      S_CK0: begin
        cmd_o.dfs_init = 1'b1;
        cmd_o.dfs_root = pid_q;
        st_d = S_D1;
      end

      S_D1: begin
        cmd_o.a_row  = stat_i.top_node[ID_W-1:0];
        cmd_o.rd_row = stat_i.top_node[ID_W-1:0];
        if (stat_i.sp_zero) begin
          res_d = '{status: ST_NONE, first_count: '0, second_count: '0};
          st_d  = S_OUT;
        end else if (!stat_i.top_node[NODE_W-1]) begin
          // process node: follow its wanted resources in order
          cmd_o.a_sel = TBL_WANT;
          if (stat_i.top_edge >= stat_i.a_len) begin
            cmd_o.dfs_pop = 1'b1;
          end else begin
            cmd_o.rd_en        = 1'b1;
            cmd_o.rd_sel       = TBL_WANT;
            cmd_o.rd_idx       = stat_i.top_edge[IDX_W-1:0];
            cmd_o.dfs_edge_inc = 1'b1;
            tproc_d = 1'b0;
            st_d    = S_D2;
          end
        end else begin
          // resource node: single edge to its holder
          cmd_o.a_sel = TBL_RQ;
          if (stat_i.top_edge != '0 || stat_i.a_len == '0) begin
            cmd_o.dfs_pop = 1'b1;
          end else begin
            cmd_o.rd_en        = 1'b1;
            cmd_o.rd_sel       = TBL_RQ;
            cmd_o.rd_idx       = '0;
            cmd_o.dfs_edge_inc = 1'b1;
            tproc_d = 1'b1;
            st_d    = S_D2;
          end
        end
      end

      S_D2: begin
        if (stat_i.t_color == COL_GREY) begin
          st_d = S_H0;
        end else begin
          if (stat_i.t_color == COL_WHITE && !stat_i.sp_full) cmd_o.dfs_push = 1'b1;
          st_d = S_D1;
        end
      end

      S_H0: begin
        cmd_o.a_sel  = TBL_HELD;
        cmd_o.a_row  = pid_q;
        cmd_o.rd_sel = TBL_HELD;
        cmd_o.rd_row = pid_q;
        if (stat_i.a_len == '0) begin
          st_d = S_W0;
        end else begin
          cmd_o.rd_en = 1'b1;
          st_d = S_H1;
        end
      end

      S_H1: begin
        r_d       = stat_i.rdata;
        h_d       = h_q + CNT_W'(1);
        sub_sel_d = TBL_HELD;
        sub_row_d = pid_q;
        pos_d     = '0;
        ret_d     = S_H2;
        st_d      = S_SH;
      end

      S_H2: begin
        cmd_o.a_sel = TBL_RQ;
        cmd_o.a_row = r_q;
        if (stat_i.a_len == '0) begin
          st_d = S_H0;
        end else begin
          sub_sel_d = TBL_RQ;
          sub_row_d = r_q;
          pos_d     = '0;
          ret_d     = S_H3;
          st_d      = S_SH;
        end
      end

      S_H3: begin
        cmd_o.a_sel  = TBL_RQ;
        cmd_o.a_row  = r_q;
        cmd_o.rd_sel = TBL_RQ;
        cmd_o.rd_row = r_q;
        if (stat_i.a_len == '0) begin
          st_d = S_H0;
        end else begin
          cmd_o.rd_en = 1'b1;
          st_d = S_H5;
        end
      end

      S_H5: begin
        // hand the resource to the next waiter in the queue
        cmd_o.a_sel   = TBL_HELD;
        cmd_o.a_row   = stat_i.rdata;
        cmd_o.wr_sel  = TBL_HELD;
        cmd_o.wr_row  = stat_i.rdata;
        cmd_o.wr_idx  = stat_i.a_len[IDX_W-1:0];
        cmd_o.wr_data = r_q;
        if (stat_i.a_len < LEN_W'(LIST_DEPTH)) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.len_op = LOP_INC;
        end
        sub_sel_d = TBL_WANT;
        sub_row_d = stat_i.rdata;
        fv_d      = r_q;
        pos_d     = '0;
        ret_d     = S_H0;
        st_d      = S_FD;
      end

      S_W0: begin
        cmd_o.a_sel  = TBL_WANT;
        cmd_o.a_row  = pid_q;
        cmd_o.rd_sel = TBL_WANT;
        cmd_o.rd_row = pid_q;
        if (stat_i.a_len == '0) begin
          if (kill_q) begin
            res_d = '{status: ST_KILL, first_count: h_q, second_count: w_q[4:0]};
          end else begin
            res_d = '{status: ST_TERM, first_count: h_q + w_q, second_count: '0};
          end
          st_d = S_OUT;
        end else begin
          cmd_o.rd_en = 1'b1;
          st_d = S_W1;
        end
      end

      S_W1: begin
        r_d       = stat_i.rdata;
        w_d       = w_q + CNT_W'(1);
        sub_sel_d = TBL_WANT;
        sub_row_d = pid_q;
        pos_d     = '0;
        ret_d     = S_W2;
        st_d      = S_SH;
      end

      S_W2: begin
        sub_sel_d = TBL_RQ;
        sub_row_d = r_q;
        fv_d      = pid_q;
        pos_d     = '0;
        ret_d     = S_W0;
        st_d      = S_FD;
      end

      S_SH: begin
        // remove entry pos: move the tail down one place, then shorten
        cmd_o.a_sel  = sub_sel_q;
        cmd_o.a_row  = sub_row_q;
        cmd_o.rd_sel = sub_sel_q;
        cmd_o.rd_row = sub_row_q;
        cmd_o.rd_idx = IDX_W'(pos_q + LEN_W'(1));
        if ((pos_q + LEN_W'(1)) < stat_i.a_len) begin
          cmd_o.rd_en = 1'b1;
          st_d = S_SHW;
        end else begin
          cmd_o.len_op = LOP_DEC;
          st_d = ret_q;
        end
      end

      S_SHW: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = sub_sel_q;
        cmd_o.wr_row  = sub_row_q;
        cmd_o.wr_idx  = pos_q[IDX_W-1:0];
        cmd_o.wr_data = stat_i.rdata;
        pos_d = pos_q + LEN_W'(1);
        st_d  = S_SH;
      end

      S_FD: begin
        cmd_o.a_sel  = sub_sel_q;
        cmd_o.a_row  = sub_row_q;
        cmd_o.rd_sel = sub_sel_q;
        cmd_o.rd_row = sub_row_q;
        cmd_o.rd_idx = pos_q[IDX_W-1:0];
        if (pos_q >= stat_i.a_len) begin
          st_d = ret_q;
        end else begin
          cmd_o.rd_en = 1'b1;
          st_d = S_FDC;
        end
      end

      S_FDC: begin
        if (stat_i.rdata == fv_q) begin
          st_d = S_SH;
        end else begin
          pos_d = pos_q + LEN_W'(1);
          st_d  = S_FD;
        end
      end

      S_OUT: begin
        // hold the result until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          st_d        = S_IDLE;
        end
      end

      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      ret_q       <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pid_q     <= pid_d;
    rid_q     <= rid_d;
    r_q       <= r_d;
    fv_q      <= fv_d;
    sub_row_q <= sub_row_d;
    sub_sel_q <= sub_sel_d;
    pos_q     <= pos_d;
    h_q       <= h_d;
    w_q       <= w_d;
    kill_q    <= kill_d;
    tproc_q   <= tproc_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

endmodule
